@@ hdl/spl_pkg.sv @@
`default_nettype none

package spl_pkg;

    // Gain numerator, 32767 << 16
    localparam logic [30:0] GAIN_NUM      = 31'd2147418112;
    localparam int          GAIN_W        = 31;
    localparam int          DIVISOR_W     = 25;

    // Reset values
    localparam logic [31:0] PEAK_RESET    = 32'd8388608;
    localparam logic [22:0] THRESH_RESET  = 23'd32768;
    localparam logic [23:0] RELEASE_RESET = 24'd1741;

    // Q8 floor of the threshold and the rounding term of the divisor
    localparam logic [31:0] Q8_MIN        = 32'd256;
    localparam logic [32:0] ROUND_Q8      = 33'd255;

    // Register indexes
    localparam logic [1:0]  CFG_THRESHOLD = 2'd0;
    localparam logic [1:0]  CFG_RELEASE   = 2'd1;
    localparam logic [1:0]  CFG_MODE      = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_PEAK,
        ST_DECAY,
        ST_FLOOR,
        ST_ATTN,
        ST_WAIT,
        ST_MUL_L,
        ST_MUL_R,
        ST_FIN
    } spl_state_t;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } spl_div_stat_t;

    // Floor shift by 16 of a magnitude product, sign applied, saturated to 32 bits
    function automatic logic [31:0] scale_sat(input logic [54:0] prod, input logic neg);
        logic [38:0] q_pos;
        logic [55:0] s_neg;
        logic [39:0] q_neg;
        logic [31:0] res;
        q_pos = prod[54:16];
        s_neg = {1'b0, prod} + 56'd65535;
        q_neg = s_neg[55:16];
        if (!neg)
        begin
            if (q_pos > 39'h007FFF_FFFF)
                res = 32'h7FFF_FFFF;
            else
                res = q_pos[31:0];
        end
        else
        begin
            if (q_neg > 40'h0080_0000_00)
                res = 32'h8000_0000;
            else
                res = 32'd0 - q_neg[31:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ hdl/stereo_peak_limiter.sv @@
`default_nettype none

// Stereo peak limiter, instant attack and linear release.
// Input channel: in_valid/in_ready carries one stereo frame per word
// (in_left, in_right, end_of_block). Output channel: out_valid/out_ready
// carries one word per frame (out_left, out_right, attenuation).
// Configuration: cfg_write with cfg_index/cfg_data writes a register
// (0 threshold_level, 1 release_step, 2 detector_mode); other indexes
// are ignored. Write only while no frame is in flight.
// For each frame the gain comes from a restoring divider that produces one
// quotient bit per cycle, and a 24x31 multiply per channel scales the two
// channels in turn. in_ready is high only while the sequencer is idle, so
// a new frame is accepted only once the previous one has written its
// result word.
// The output register holds a finished word while the receiver stalls; the
// next frame is still accepted and processed, and waits in its last step
// until the output register is free.
// Reset sets the peak to 32768 << 8, the held attenuation to zero and the
// registers to their defaults, and empties the output register.
module stereo_peak_limiter (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [23:0] in_left,
    input  wire logic signed [23:0] in_right,
    input  wire logic               end_of_block,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      out_left,
    output logic signed [31:0]      out_right,
    output logic        [23:0]      attenuation,
    input  wire logic               cfg_write,
    input  wire logic        [1:0]  cfg_index,
    input  wire logic        [23:0] cfg_data
);

    spl_pkg::spl_state_t state_reg, state_next;

    logic [22:0] thresh_reg;
    logic [23:0] release_reg;
    logic        mode_reg;

    logic [31:0] peak_reg, peak_next;
    logic [23:0] held_reg, held_next;
    logic        attack_reg, attack_next;

    logic [23:0] samp_l_reg, samp_l_next;
    logic [23:0] samp_r_reg, samp_r_next;
    logic        eob_reg, eob_next;
    logic [23:0] mag_l_reg, mag_l_next;
    logic [23:0] mag_r_reg, mag_r_next;
    logic [31:0] level_reg, level_next;
    logic [54:0] prod_reg, prod_next;
    logic [31:0] left_res_reg, left_res_next;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_left_reg, out_left_next;
    logic [31:0] out_right_reg, out_right_next;
    logic [23:0] attn_out_reg, attn_out_next;

    logic                               div_start;
    logic [spl_pkg::DIVISOR_W-1:0]      div_divisor;
    spl_pkg::spl_div_stat_t             div_stat;
    logic [spl_pkg::GAIN_W-1:0]         gain;

    logic [31:0] th_q8;

    spl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (div_divisor),
        .status   (div_stat),
        .quotient (gain)
    );

    // Threshold in Q8, never below 256
    assign th_q8 = (thresh_reg == 23'd0) ? spl_pkg::Q8_MIN : {1'b0, thresh_reg, 8'd0};

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg  <= spl_pkg::THRESH_RESET;
            release_reg <= spl_pkg::RELEASE_RESET;
            mode_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                spl_pkg::CFG_THRESHOLD: thresh_reg  <= cfg_data[22:0];
                spl_pkg::CFG_RELEASE:   release_reg <= cfg_data;
                spl_pkg::CFG_MODE:      mode_reg    <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    // Sequencer: next state and datapath steps
    always_comb
    begin
        logic [23:0] mx;
        logic [23:0] mn;
        logic [31:0] src;
        logic [32:0] rsum;
        logic [31:0] diff;

        state_next     = state_reg;
        peak_next      = peak_reg;
        held_next      = held_reg;
        attack_next    = attack_reg;
        samp_l_next    = samp_l_reg;
        samp_r_next    = samp_r_reg;
        eob_next       = eob_reg;
        mag_l_next     = mag_l_reg;
        mag_r_next     = mag_r_reg;
        level_next     = level_reg;
        prod_next      = prod_reg;
        left_res_next  = left_res_reg;
        out_left_next  = out_left_reg;
        out_right_next = out_right_reg;
        attn_out_next  = attn_out_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        in_ready       = 1'b0;
        div_start      = 1'b0;

        mx   = (mag_l_reg > mag_r_reg) ? mag_l_reg : mag_r_reg;
        mn   = (mag_l_reg > mag_r_reg) ? mag_r_reg : mag_l_reg;
        src  = (level_reg > peak_reg) ? level_reg : peak_reg;
        rsum = {1'b0, src} + spl_pkg::ROUND_Q8;
        div_divisor = (rsum[32:8] == '0) ? spl_pkg::DIVISOR_W'(1) : rsum[32:8];
        diff = peak_reg - th_q8;

        case (state_reg)
            spl_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    samp_l_next = in_left;
                    samp_r_next = in_right;
                    eob_next    = end_of_block;
                    state_next  = spl_pkg::ST_PREP;
                end
            end
            // magnitudes of both channels
            spl_pkg::ST_PREP:
            begin
                mag_l_next = samp_l_reg[23] ? (~samp_l_reg + 24'd1) : samp_l_reg;
                mag_r_next = samp_r_reg[23] ? (~samp_r_reg + 24'd1) : samp_r_reg;
                state_next = spl_pkg::ST_PEAK;
            end
            // detector level; gain divisor from the larger of level and the peak before decay
            spl_pkg::ST_PEAK:
            begin
                level_next = mode_reg ? ({mx, 8'd0} + {1'b0, mn, 7'd0}) : {mx, 8'd0};
                state_next = spl_pkg::ST_DECAY;
            end
            spl_pkg::ST_DECAY:
            begin
                div_start   = 1'b1;
                attack_next = (level_reg > peak_reg);
                if (level_reg > peak_reg)
                    peak_next = level_reg;
                else if (peak_reg > {8'd0, release_reg})
                    peak_next = peak_reg - {8'd0, release_reg};
                else
                    peak_next = 32'd0;
                state_next = spl_pkg::ST_FLOOR;
            end
            spl_pkg::ST_FLOOR:
            begin
                if (!attack_reg && (peak_reg < th_q8))
                    peak_next = th_q8;
                state_next = spl_pkg::ST_ATTN;
            end
            // latch attenuation at block end
            spl_pkg::ST_ATTN:
            begin
                if (eob_reg)
                    held_next = (peak_reg > th_q8) ? diff[31:8] : 24'd0;
                state_next = spl_pkg::ST_WAIT;
            end
            spl_pkg::ST_WAIT:
            begin
                if (div_stat.done)
                    state_next = spl_pkg::ST_MUL_L;
            end
            spl_pkg::ST_MUL_L:
            begin
                prod_next  = 55'(mag_l_reg) * 55'(gain);
                state_next = spl_pkg::ST_MUL_R;
            end
            spl_pkg::ST_MUL_R:
            begin
                left_res_next = spl_pkg::scale_sat(prod_reg, samp_l_reg[23]);
                prod_next     = 55'(mag_r_reg) * 55'(gain);
                state_next    = spl_pkg::ST_FIN;
            end
            // write the result word once the output register is free
            spl_pkg::ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_left_next  = left_res_reg;
                    out_right_next = spl_pkg::scale_sat(prod_reg, samp_r_reg[23]);
                    attn_out_next  = held_reg;
                    out_valid_next = 1'b1;
                    state_next     = spl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spl_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spl_pkg::ST_IDLE;
            peak_reg      <= spl_pkg::PEAK_RESET;
            held_reg      <= 24'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            peak_reg      <= peak_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        attack_reg    <= attack_next;
        samp_l_reg    <= samp_l_next;
        samp_r_reg    <= samp_r_next;
        eob_reg       <= eob_next;
        mag_l_reg     <= mag_l_next;
        mag_r_reg     <= mag_r_next;
        level_reg     <= level_next;
        prod_reg      <= prod_next;
        left_res_reg  <= left_res_next;
        out_left_reg  <= out_left_next;
        out_right_reg <= out_right_next;
        attn_out_reg  <= attn_out_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_left    = out_left_reg;
    assign out_right   = out_right_reg;
    assign attenuation = attn_out_reg;

`ifndef SYNTHESIS
    // peak never sits below the Q8 floor between frames
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spl_pkg::ST_IDLE) |-> (peak_reg >= spl_pkg::Q8_MIN))
        else $error("peak below floor while idle");

    // no new frame while the divider runs
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> !in_ready)
        else $error("input ready during divide");

    // a pending word is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spl_pkg::ST_FIN && out_valid_reg && !out_ready)
            |=> (state_reg == spl_pkg::ST_FIN))
        else $error("result written over a pending word");
`endif

endmodule

`default_nettype wire

@@ hdl/spl_div.sv @@
`default_nettype none

// Restoring divider: fixed gain numerator over a 25-bit divisor, one bit a cycle
module spl_div (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [spl_pkg::DIVISOR_W-1:0]      divisor,
    output spl_pkg::spl_div_stat_t                  status,
    output logic      [spl_pkg::GAIN_W-1:0]         quotient
);

    logic [spl_pkg::DIVISOR_W-1:0] div_reg;
    logic [spl_pkg::DIVISOR_W-1:0] rem_reg;
    logic [spl_pkg::GAIN_W-1:0]    quo_reg;
    logic [4:0]                    cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [spl_pkg::DIVISOR_W:0]   trial;
    logic                          take;

    // Shift in the next numerator bit and try the subtract
    always_comb
    begin
        trial = {rem_reg, spl_pkg::GAIN_NUM[cnt_reg]};
        take  = (trial >= {1'b0, div_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 5'(spl_pkg::GAIN_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 5'd0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg - 5'd1;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (take)
                rem_reg <= spl_pkg::DIVISOR_W'(trial - {1'b0, div_reg});
            else
                rem_reg <= trial[spl_pkg::DIVISOR_W-1:0];
            quo_reg <= {quo_reg[spl_pkg::GAIN_W-2:0], take};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

`default_nettype wire
